FILE: sv/mkds_pkg.sv
// shared types and constants for the multi-key debounce scanner
`timescale 1ns / 1ps

package mkds_pkg;

  localparam int KIND_W = 2;
  localparam int LVL_W  = 4;
  localparam int NOW_W  = 32;
  localparam int KIDX_W = 2;
  localparam int EKEY_W = 2;
  localparam int DEB_W  = 16;
  localparam int CIDX_W = 1;

  localparam logic [KIND_W-1:0] KIND_SCAN   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FETCH  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_IGNORE = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_DEBOUNCE = 1'b0;
  localparam logic [CIDX_W-1:0] CFG_NORMAL   = 1'b1;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [LVL_W-1:0] NORMAL_RESET   = 4'd0;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LVL_W-1:0]  pins;
    logic [NOW_W-1:0]  now;
    logic [KIDX_W-1:0] key_index;
  } req_t;

  // used for the key bank's posted event, the mailbox and the result
  typedef struct packed {
    logic              valid;
    logic [EKEY_W-1:0] key;
    logic              pressed;
  } evt_t;

endpackage

FILE: sv/mkds_key_bank.sv
// per-key debounce state, scan pointer and press/release detection
`timescale 1ns / 1ps

module mkds_key_bank import mkds_pkg::*; #(
  parameter int NUM_KEYS = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  req_t             req,
  input  logic [DEB_W-1:0] debounce_ms,
  input  logic [LVL_W-1:0] normal_levels,
  output evt_t             kev
);

  localparam int KW    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int EXT_W = (NUM_KEYS > LVL_W) ? NUM_KEYS : LVL_W;
  localparam logic [KW-1:0] LAST_KEY = KW'(NUM_KEYS - 1);

  logic [NUM_KEYS-1:0] lvl_r, lvl_nxt;
  logic [NUM_KEYS-1:0] ign_r, ign_nxt;
  logic [NOW_W-1:0]    stamp_r   [NUM_KEYS];
  logic [NOW_W-1:0]    stamp_nxt [NUM_KEYS];
  logic [KW-1:0]       ptr_r, ptr_nxt;

  logic [EXT_W-1:0] pins_ext;
  logic [EXT_W-1:0] norm_ext;
  logic             lvl_in;
  logic             norm;
  logic [NOW_W-1:0] elapsed;
  logic             stale;
  logic             key_ok;
  logic [KW-1:0]    key_sel;

  // keys above the 4-bit fields read level 0
  assign pins_ext = EXT_W'(req.pins);
  assign norm_ext = EXT_W'(normal_levels);
  assign lvl_in   = pins_ext[ptr_r];
  assign norm     = norm_ext[ptr_r];
  assign elapsed  = req.now - stamp_r[ptr_r];
  assign stale    = (elapsed >= NOW_W'(debounce_ms));
  assign key_ok   = (32'(req.key_index) < NUM_KEYS);
  assign key_sel  = KW'(req.key_index);

  always_comb begin
    lvl_nxt   = lvl_r;
    ign_nxt   = ign_r;
    stamp_nxt = stamp_r;
    ptr_nxt   = ptr_r;
    kev       = '0;
    if (adv) begin
      case (req.kind)
        KIND_SCAN: begin
          ptr_nxt = (ptr_r == LAST_KEY) ? '0 : ptr_r + KW'(1);
          if (lvl_r[ptr_r] == lvl_in) begin
            stamp_nxt[ptr_r] = req.now;
          end else if (stale) begin
            stamp_nxt[ptr_r] = req.now;
            lvl_nxt[ptr_r]   = lvl_in;
            if (lvl_in == norm) begin
              if (!ign_r[ptr_r]) begin
                kev.valid   = 1'b1;
                kev.key     = EKEY_W'(ptr_r);
                kev.pressed = 1'b0;
              end
            end else begin
              ign_nxt[ptr_r] = 1'b0;
              kev.valid      = 1'b1;
              kev.key        = EKEY_W'(ptr_r);
              kev.pressed    = 1'b1;
            end
          end
        end
        KIND_IGNORE: begin
          if (key_ok) begin
            ign_nxt[key_sel] = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r <= NUM_KEYS'(NORMAL_RESET);
      ign_r <= '0;
      ptr_r <= '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        stamp_r[i] <= '0;
      end
    end else begin
      lvl_r   <= lvl_nxt;
      ign_r   <= ign_nxt;
      ptr_r   <= ptr_nxt;
      stamp_r <= stamp_nxt;
    end
  end

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ptr_r) < NUM_KEYS)
    else $error("scan pointer out of range");

  a_post_on_scan: assert property (@(posedge clk) disable iff (!rst_n)
    kev.valid |-> (adv && req.kind == KIND_SCAN))
    else $error("event posted outside a scan");

  a_press_clears_ignore: assert property (@(posedge clk) disable iff (!rst_n)
    (kev.valid && kev.pressed) |=> !ign_r[$past(ptr_r)])
    else $error("press left the ignore flag set");

endmodule

FILE: sv/mkds_mailbox.sv
// single-entry event mailbox and result selection
`timescale 1ns / 1ps

module mkds_mailbox import mkds_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic [KIND_W-1:0] kind,
  input  evt_t              kev,
  output evt_t              res
);

  evt_t mbox_r, mbox_nxt;
  evt_t after;

  // a new event overwrites whatever the mailbox held
  assign after = kev.valid ? kev : mbox_r;
  assign res   = after.valid ? after : '0;

  always_comb begin
    mbox_nxt = mbox_r;
    if (adv) begin
      mbox_nxt = (kind == KIND_FETCH) ? '0 : after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbox_r <= '0;
    end else begin
      mbox_r <= mbox_nxt;
    end
  end

  a_fetch_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && kind == KIND_FETCH) |=> !mbox_r.valid)
    else $error("mailbox not emptied by fetch");

endmodule

FILE: sv/multi_key_debounce_scanner_core.sv
// top level of the multi-key debounce scanner
`timescale 1ns / 1ps

// usage:
// in_* carries one beat per item: kind 0 scans the next key round robin,
// kind 1 fetches and empties the event mailbox, kind 2 marks key_index so
// its release is not reported until its next press. every item gives
// exactly one out_* beat: the mailbox content, before a fetch empties it.
// cfg_* writes debounce_ms (index 0) or normal_levels (index 1); cfg_ready
// is always high, writes are expected only while the block is idle.
// an accepted beat sits in the input register, then the compare and update
// logic writes the result register, which drives out_*. one item per cycle
// is sustained while out_stall is low; the rate is set by the single update
// pass on the scanned key's slot.
// when out_stall holds, the result register keeps its beat and the input
// register fills once more; in_stall then rises until the result is taken.
// reset (rst_n low, synchronous) empties both registers and the mailbox,
// points the scan at key zero, clears timestamps and ignore flags, sets
// debounced levels to the normal reset levels and restores the registers.

module multi_key_debounce_scanner_core import mkds_pkg::*; #(
  parameter int NUM_KEYS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [LVL_W-1:0]  in_pin_levels,
  input  logic [NOW_W-1:0]  in_now_ms,
  input  logic [KIDX_W-1:0] in_key_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_event_valid,
  output logic [EKEY_W-1:0] out_event_key,
  output logic              out_event_pressed,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [DEB_W-1:0]  cfg_data
);

  logic             in_valid_r, in_valid_nxt;
  req_t             req_r, req_nxt;
  logic             out_valid_r, out_valid_nxt;
  evt_t             res_r, res_nxt;
  logic [DEB_W-1:0] debounce_r, debounce_nxt;
  logic [LVL_W-1:0] normal_r, normal_nxt;
  logic             adv;
  evt_t             kev;
  evt_t             res;

  assign adv       = in_valid_r & ~(out_valid_r & out_stall);
  assign in_stall  = in_valid_r & out_valid_r & out_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_valid_nxt = in_valid_r;
    req_nxt      = req_r;
    if (!in_stall) begin
      in_valid_nxt = in_valid;
      if (in_valid) begin
        req_nxt = '{kind: in_kind, pins: in_pin_levels, now: in_now_ms,
                    key_index: in_key_index};
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    res_nxt       = res_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
      res_nxt       = res;
    end
  end

  always_comb begin
    debounce_nxt = debounce_r;
    normal_nxt   = normal_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: debounce_nxt = cfg_data;
        CFG_NORMAL:   normal_nxt   = LVL_W'(cfg_data);
        default: ;
      endcase
    end
  end

  mkds_key_bank #(
    .NUM_KEYS (NUM_KEYS)
  ) u_key_bank (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .req           (req_r),
    .debounce_ms   (debounce_r),
    .normal_levels (normal_r),
    .kev           (kev)
  );

  mkds_mailbox u_mailbox (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .kind  (req_r.kind),
    .kev   (kev),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      debounce_r  <= DEBOUNCE_RESET;
      normal_r    <= NORMAL_RESET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      debounce_r  <= debounce_nxt;
      normal_r    <= normal_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    res_r <= res_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_event_valid   = res_r.valid;
  assign out_event_key     = res_r.key;
  assign out_event_pressed = res_r.pressed;

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("advanced item did not reach the result register");

  a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.valid) |-> (res_r.key == '0 && !res_r.pressed))
    else $error("empty result carries nonzero fields");

endmodule

FILE: bench/multi_key_debounce_scanner_core_test.sv
// self-checking testbench for the multi-key debounce scanner core
`timescale 1ns / 1ps

module multi_key_debounce_scanner_core_test import mkds_pkg::*;;

  localparam int KEYS = 4;
  localparam int IDLE_LIMIT = 2000;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KIND_W-1:0] in_kind = '0;
  logic [LVL_W-1:0] in_pin_levels = '0;
  logic [NOW_W-1:0] in_now_ms = '0;
  logic [KIDX_W-1:0] in_key_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_event_valid;
  logic [EKEY_W-1:0] out_event_key;
  logic out_event_pressed;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [DEB_W-1:0] cfg_data = '0;

  // when set, neither side idles
  bit steady = 1'b0;
  logic [NOW_W-1:0] now_cur;
  logic [LVL_W-1:0] pins_cur;

  multi_key_debounce_scanner_core #(.NUM_KEYS(KEYS)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_pin_levels(in_pin_levels),
    .in_now_ms(in_now_ms),
    .in_key_index(in_key_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_event_valid(out_event_valid),
    .out_event_key(out_event_key),
    .out_event_pressed(out_event_pressed),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  class debounce_scoreboard;
    logic [DEB_W-1:0] debounce_ms;
    logic [LVL_W-1:0] normal_levels;
    logic stable_level [KEYS];
    logic [NOW_W-1:0] change_stamp [KEYS];
    logic skip_release [KEYS];
    int scan_key;
    evt_t mbox;
    evt_t event_q [$];
    int mismatches;

    function new();
      debounce_ms = DEBOUNCE_RESET;
      normal_levels = NORMAL_RESET;
      for (int k = 0; k < KEYS; k++) begin
        stable_level[k] = NORMAL_RESET[k];
        change_stamp[k] = '0;
        skip_release[k] = 1'b0;
      end
      scan_key = 0;
      mbox = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] idx, logic [DEB_W-1:0] data);
      if (idx == CFG_DEBOUNCE) debounce_ms = data;
      else if (idx == CFG_NORMAL) normal_levels = data[LVL_W-1:0];
    endfunction

    function void note_item(logic [KIND_W-1:0] kind, logic [LVL_W-1:0] pins,
                            logic [NOW_W-1:0] now, logic [KIDX_W-1:0] key);
      int k;
      logic lvl;
      logic [NOW_W-1:0] elapsed;
      evt_t ev;
      case (kind)
        KIND_SCAN: begin
          k = scan_key;
          scan_key = (k + 1 >= KEYS) ? 0 : k + 1;
          lvl = pins[k];
          elapsed = now - change_stamp[k];
          if (stable_level[k] == lvl) begin
            change_stamp[k] = now;
          end else if (elapsed >= NOW_W'(debounce_ms)) begin
            change_stamp[k] = now;
            stable_level[k] = lvl;
            if (lvl == normal_levels[k]) begin
              if (!skip_release[k]) begin
                mbox.valid = 1'b1;
                mbox.key = EKEY_W'(k);
                mbox.pressed = 1'b0;
              end
            end else begin
              skip_release[k] = 1'b0;
              mbox.valid = 1'b1;
              mbox.key = EKEY_W'(k);
              mbox.pressed = 1'b1;
            end
          end
        end
        KIND_IGNORE: begin
          if (int'(key) < KEYS) skip_release[key] = 1'b1;
        end
        default: ;
      endcase
      ev = mbox.valid ? mbox : '0;
      if (kind == KIND_FETCH) mbox = '0;
      event_q.push_back(ev);
    endfunction

    function void check_event(logic v, logic [EKEY_W-1:0] key, logic pressed);
      evt_t want;
      if (event_q.size() == 0) begin
        $error("result beat with nothing pending");
        mismatches++;
        return;
      end
      want = event_q.pop_front();
      if (v !== want.valid) begin
        $error("event_valid: expected %0d, actual %0d", want.valid, v);
        mismatches++;
      end
      if (key !== want.key) begin
        $error("event_key: expected %0d, actual %0d", want.key, key);
        mismatches++;
      end
      if (pressed !== want.pressed) begin
        $error("event_pressed: expected %0d, actual %0d", want.pressed, pressed);
        mismatches++;
      end
    endfunction

    function int waiting();
      return event_q.size();
    endfunction
  endclass

  debounce_scoreboard sb;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // monitor and watchdog
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_item(in_kind, in_pin_levels, in_now_ms, in_key_index);
      if (out_valid && !out_stall)
        sb.check_event(out_event_valid, out_event_key, out_event_pressed);
      if (cfg_valid && cfg_ready)
        sb.write_reg(cfg_index, cfg_data);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side back-pressure
  int stall_left = 0;
  int free_left = 0;
  always @(posedge clk) begin
    if (steady) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (free_left > 0) begin
      free_left--;
      out_stall <= 1'b0;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: free_left = $urandom_range(0, 20);
        9: stall_left = $urandom_range(8, 40);
        default: stall_left = $urandom_range(1, 3);
      endcase
      out_stall <= 1'b0;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [LVL_W-1:0] pins,
                           input logic [NOW_W-1:0] now, input logic [KIDX_W-1:0] key);
    int gap;
    in_valid <= 1'b1;
    in_kind <= kind;
    in_pin_levels <= pins;
    in_now_ms <= now;
    in_key_index <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the sender until every pending event beat is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.waiting() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CIDX_W-1:0] idx, input logic [DEB_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [DEB_W-1:0] deb, input logic [LVL_W-1:0] normal);
    logic [DEB_W-1:0] d;
    drain();
    write_cfg(CFG_DEBOUNCE, deb);
    d = DEB_W'($urandom);
    d[LVL_W-1:0] = normal;
    write_cfg(CFG_NORMAL, d);
  endtask

  task automatic run_directed();
    // reset settings: 20 ms, all keys released at level 0
    send_item(KIND_SCAN, 4'b0001, 32'd5, 2'd0);          // too early
    send_item(KIND_SCAN, 4'b1111, 32'd20, 2'd0);         // exactly at threshold, press
    send_item(KIND_UNUSED, 4'b1111, 32'hFFFF_FFFF, 2'd3);
    send_item(KIND_FETCH, 4'b0000, 32'd0, 2'd0);
    send_item(KIND_FETCH, 4'b0000, 32'd0, 2'd0);         // empty mailbox
    send_item(KIND_IGNORE, 4'b0000, 32'd0, 2'd1);
    send_item(KIND_SCAN, 4'b0000, 32'd25, 2'd0);         // same level, refresh
    send_item(KIND_SCAN, 4'b1000, 32'hFFFF_FFFF, 2'd0);
    send_item(KIND_SCAN, 4'b0001, 32'd24, 2'd0);         // overwrites mailbox
    send_item(KIND_SCAN, 4'b0000, 32'd60, 2'd0);         // release swallowed
    send_item(KIND_FETCH, 4'b0000, 32'd0, 2'd0);
    send_item(KIND_SCAN, 4'b0100, 32'd44, 2'd0);
    send_item(KIND_SCAN, 4'b0000, 32'h0000_0012, 2'd0);  // wrapped, one short
    send_item(KIND_SCAN, 4'b0000, 32'd60, 2'd0);
    send_item(KIND_SCAN, 4'b0000, 32'd61, 2'd0);
    send_item(KIND_SCAN, 4'b0100, 32'd45, 2'd0);
    send_item(KIND_SCAN, 4'b0000, 32'h0000_0013, 2'd0);  // wrapped, on time
    send_item(KIND_FETCH, 4'b0000, 32'd0, 2'd0);
    send_item(KIND_IGNORE, 4'b0000, 32'd0, 2'd3);
    send_item(KIND_IGNORE, 4'b0000, 32'd0, 2'd2);
    send_item(KIND_SCAN, 4'b0001, 32'd0, 2'd0);
    // zero debounce, inverted normal levels: stored levels stay as they are
    set_regs(16'd0, 4'b1111);
    send_item(KIND_SCAN, 4'b1111, 32'd0, 2'd0);
    send_item(KIND_SCAN, 4'b0000, 32'd0, 2'd0);
    send_item(KIND_FETCH, 4'b0000, 32'd0, 2'd0);
    set_regs(16'hFFFF, 4'b0000);
    send_item(KIND_SCAN, 4'b0101, 32'd65534, 2'd0);
    send_item(KIND_SCAN, 4'b0101, 32'd65535, 2'd0);
  endtask

  task automatic run_phase(input int deb, input logic [LVL_W-1:0] normal, input int count,
                           input logic [NOW_W-1:0] start_now);
    logic [KIND_W-1:0] kind;
    logic [LVL_W-1:0] pins;
    logic [NOW_W-1:0] step;
    int r;
    set_regs(DEB_W'(deb), normal);
    now_cur = start_now;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        // noise beat: anything goes
        send_item(KIND_W'($urandom), LVL_W'($urandom), $urandom, KIDX_W'($urandom));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) step = $urandom_range(0, deb / 3 + 1);
        else if (r < 95) step = $urandom_range(deb / 2, deb + deb / 2 + 2);
        else step = $urandom;
        now_cur = now_cur + step;
        if ($urandom_range(0, 7) == 0) pins_cur[$urandom_range(0, KEYS - 1)] ^= 1'b1;
        pins = pins_cur;
        // contact bounce on a single beat
        if ($urandom_range(0, 9) == 0) pins ^= LVL_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 68) kind = KIND_SCAN;
        else if (r < 86) kind = KIND_FETCH;
        else if (r < 96) kind = KIND_IGNORE;
        else kind = KIND_UNUSED;
        send_item(kind, pins, now_cur, KIDX_W'($urandom));
      end
      if ($urandom_range(0, 199) == 0) drain();
    end
  endtask

  initial begin
    sb = new();
    pins_cur = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_phase(20, 4'b0000, 260, 32'd0);
    run_phase(0, 4'b1111, 260, $urandom);
    run_phase(65535, 4'b1001, 260, 32'hFFFF_0000);
    run_phase(3, 4'b0110, 260, 32'hFFFF_FF00);
    run_phase(1, 4'b0000, 260, 32'd100);
    run_phase($urandom_range(0, 200), LVL_W'($urandom), 260, $urandom);
    drain();
    steady = 1'b1;
    run_phase(7, 4'b1010, 260, 32'd0);
    drain();
    steady = 1'b0;
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.waiting() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
sv/mkds_pkg.sv
sv/mkds_key_bank.sv
sv/mkds_mailbox.sv
sv/multi_key_debounce_scanner_core.sv
bench/multi_key_debounce_scanner_core_test.sv
